/* hdl/qsc_pkg.sv */
// Package for the quadrature step counter: state, configuration and result
// types, the quarter-step transition table and the register index codes.
// Depends on nothing; used by qsc_step and quadrature_step_counter.
package qsc_pkg;

    localparam int COUNT_W = 32;

    // Configuration register indexes.
    localparam logic [2:0] CFG_INVERT_DIRECTION  = 3'd0;
    localparam logic [2:0] CFG_DOUBLE_RESOLUTION = 3'd1;
    localparam logic [2:0] CFG_BOUNDS_ENABLE     = 3'd2;
    localparam logic [2:0] CFG_LOWER_LIMIT       = 3'd3;
    localparam logic [2:0] CFG_UPPER_LIMIT       = 3'd4;

    // Quarter-step delta indexed by {old phase, new phase}.
    localparam logic signed [1:0] QUARTER_DELTA [16] = '{
         2'sd0, -2'sd1,  2'sd1,  2'sd0,
         2'sd1,  2'sd0,  2'sd0, -2'sd1,
        -2'sd1,  2'sd0,  2'sd0,  2'sd1,
         2'sd0,  2'sd1, -2'sd1,  2'sd0
    };

    typedef struct packed {
        logic                      invert;
        logic                      double_res;
        logic                      bounds_en;
        logic signed [COUNT_W-1:0] lower;
        logic signed [COUNT_W-1:0] upper;
    } t_cfg;

    typedef struct packed {
        logic                      synced;
        logic [1:0]                prev_phase;
        logic signed [3:0]         accum;
        logic signed [1:0]         last_sign;
        logic                      dir;
        logic signed [COUNT_W-1:0] net;
        logic [COUNT_W-1:0]        total;
    } t_state;

    typedef struct packed {
        logic signed [1:0]         step_event;
        logic signed [1:0]         boundary_hit;
        logic                      last_direction;
        logic signed [COUNT_W-1:0] net_count;
        logic [COUNT_W-1:0]        total_count;
    } t_result;

endpackage

/* hdl/qsc_step.sv */
// Next-state and result logic for one item of the quadrature step counter.
// Purely combinational; depends on qsc_pkg for types and the transition table.
module qsc_step
    import qsc_pkg::*;
(
    input  t_cfg       i_cfg,
    input  t_state     i_state,
    input  logic       i_func,
    input  logic [1:0] i_phase,
    output t_state     o_state,
    output t_result    o_result
);

    logic [3:0]                idx;
    logic signed [2:0]         tab;
    logic signed [2:0]         dq;
    logic                      both_change;
    logic signed [4:0]         sum;
    logic signed [4:0]         thr;
    logic                      up;
    logic                      dn;
    logic signed [4:0]         accum_adj;
    logic signed [COUNT_W:0]   p;
    logic                      reject;

    assign idx         = {i_state.prev_phase, i_phase};
    assign tab         = $signed({QUARTER_DELTA[idx][1], QUARTER_DELTA[idx]});
    assign both_change = ((i_state.prev_phase ^ i_phase) == 2'b11);

    always_comb begin
        if (tab != 3'sd0) begin
            dq = i_cfg.invert ? -tab : tab;
        end else if (both_change && i_state.last_sign != 2'sd0) begin
            // Missed quarter: count two quarters in the last direction seen.
            dq = $signed({i_state.last_sign, 1'b0});
        end else begin
            dq = 3'sd0;
        end
    end

    assign sum = $signed({i_state.accum[3], i_state.accum}) + $signed({{2{dq[2]}}, dq});
    assign thr = i_cfg.double_res ? 5'sd2 : 5'sd4;
    assign up  = (dq != 3'sd0) && (sum >= thr);
    assign dn  = (dq != 3'sd0) && (sum <= -thr);

    always_comb begin
        if (up) begin
            accum_adj = sum - thr;
        end else if (dn) begin
            accum_adj = sum + thr;
        end else begin
            accum_adj = sum;
        end
    end

    // The bound check uses the exact next value, one bit wider than the counter.
    assign p = $signed({i_state.net[COUNT_W-1], i_state.net})
             + (up ? (COUNT_W+1)'(1) : {(COUNT_W+1){1'b1}});
    assign reject = i_cfg.bounds_en && (up || dn)
                  && (p < $signed({i_cfg.lower[COUNT_W-1], i_cfg.lower})
                   || p > $signed({i_cfg.upper[COUNT_W-1], i_cfg.upper}));

    always_comb begin
        o_state               = i_state;
        o_result.step_event   = 2'sd0;
        o_result.boundary_hit = 2'sd0;
        if (i_func) begin
            o_state.net       = '0;
            o_state.total     = '0;
            o_state.accum     = 4'sd0;
            o_state.last_sign = 2'sd0;
            o_state.synced    = 1'b0;
        end else if (!i_state.synced) begin
            o_state.prev_phase = i_phase;
            o_state.synced     = 1'b1;
        end else begin
            o_state.prev_phase = i_phase;
            if (dq != 3'sd0) begin
                o_state.last_sign = dq[2] ? -2'sd1 : 2'sd1;
                o_state.accum     = accum_adj[3:0];
            end
            if (up || dn) begin
                o_state.dir = up;
                if (reject) begin
                    o_result.boundary_hit = up ? 2'sd1 : -2'sd1;
                    o_state.accum         = 4'sd0;
                end else begin
                    o_result.step_event = up ? 2'sd1 : -2'sd1;
                    o_state.net         = up ? i_state.net + COUNT_W'(1)
                                             : i_state.net - COUNT_W'(1);
                    o_state.total       = i_state.total + COUNT_W'(1);
                end
            end
        end
        o_result.last_direction = o_state.dir;
        o_result.net_count      = o_state.net;
        o_result.total_count    = o_state.total;
    end

endmodule

/* hdl/quadrature_step_counter.sv */
// Top level of the quadrature step counter: input register, counter state,
// configuration registers and result register. Depends on qsc_pkg, qsc_step.
//
//  Channel   Handshake            Payload
//  s (in)    i_s_tvalid/o_s_tready  tuser: func; tdata: pin_a, pin_b
//  m (out)   o_m_tvalid/i_m_tready  tdata: step_event .. total_count
//  cfg       i_cfg_we               i_cfg_addr, i_cfg_data
//
// One sample per clock while the output is not stalled: an accepted word sits in
// the input register, the step logic runs and its result lands in the output
// register.
// Synchronous active-low reset clears configuration, counters and valid flags.
// A stalled output holds its word and the input register takes one more word.
module quadrature_step_counter
    import qsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [0] pin_a, [1] pin_b, rest zero
    input  logic        i_s_tuser,   // [0] func
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [1:0] step_event, [3:2] boundary_hit,
                                     // [4] last_direction, [36:5] net_count,
                                     // [68:37] total_count, rest zero
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_data
);

    t_cfg       r_cfg;
    t_state     r_state;
    t_state     n_state;
    t_result    n_result;
    t_result    r_out;
    logic       r_out_valid;
    logic       r_in_valid;
    logic       r_in_func;
    logic [1:0] r_in_phase;
    logic       move;
    logic       in_accept;

    assign move       = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || move;
    assign in_accept  = i_s_tvalid && o_s_tready;

    qsc_step u_step (
        .i_cfg    (r_cfg),
        .i_state  (r_state),
        .i_func   (r_in_func),
        .i_phase  (r_in_phase),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_INVERT_DIRECTION:  r_cfg.invert     <= i_cfg_data[0];
                CFG_DOUBLE_RESOLUTION: r_cfg.double_res <= i_cfg_data[0];
                CFG_BOUNDS_ENABLE:     r_cfg.bounds_en  <= i_cfg_data[0];
                CFG_LOWER_LIMIT:       r_cfg.lower      <= $signed(i_cfg_data);
                CFG_UPPER_LIMIT:       r_cfg.upper      <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (move) begin
                r_in_valid <= 1'b0;
            end
            if (move) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_func  <= i_s_tuser;
            r_in_phase <= {i_s_tdata[0], i_s_tdata[1]};
        end
        if (move) begin
            r_out <= n_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out.total_count, r_out.net_count,
                         r_out.last_direction, r_out.boundary_hit, r_out.step_event};

    // A result never reports an accepted and a rejected detent together.
    a_step_or_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.step_event == 2'sd0 || r_out.boundary_hit == 2'sd0))
        else $error("step_event and boundary_hit both set");

    // A clear word leaves both counters at zero.
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && r_in_func) |=> (r_state.net == '0 && r_state.total == '0))
        else $error("counters not cleared");

    // The total count advances by at most one per word.
    a_total_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && !r_in_func) |=> (r_state.total == $past(r_state.total)
                               || r_state.total == $past(r_state.total) + COUNT_W'(1)))
        else $error("total count jumped");

    // The quarter accumulator stays within five quarters of zero.
    a_accum_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.accum >= -4'sd5 && r_state.accum <= 4'sd5))
        else $error("quarter accumulator out of range");

    // The reported direction follows the accepted step.
    a_dir_follows_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.step_event != 2'sd0)
            |-> (r_out.last_direction == (r_out.step_event == 2'sd1)))
        else $error("last_direction disagrees with step_event");

endmodule

/* tb/qsc_scoreboard_pkg.sv */
// Scoreboard for the quadrature step counter testbench: a predictor of the
// counter state and a queue of expected result words. Depends on qsc_pkg.
package qsc_scoreboard_pkg;

    import qsc_pkg::*;

    // Quarter-step delta indexed by {old phase, new phase}; 0 -> 2 -> 3 -> 1 is forward.
    localparam int QUARTER_STEP [16] = '{
         0, -1,  1,  0,
         1,  0,  0, -1,
        -1,  0,  0,  1,
         0,  1, -1,  0
    };

    class qsc_scoreboard;

        // Configuration copy.
        bit     invert;
        bit     double_res;
        bit     bounds_en;
        longint lower;
        longint upper;

        // Counter state copy.
        bit               synced;
        bit [1:0]         prev_phase;
        int               accum;
        int               last_sign;
        bit               dir;
        bit [COUNT_W-1:0] net;
        bit [COUNT_W-1:0] total;

        t_result expected_words [$];
        int      errors;
        int      checked;
        int      detents;
        int      rejects;
        int      clears;

        function void configure(logic [2:0] idx, logic [31:0] value);
            case (idx)
                CFG_INVERT_DIRECTION:  invert = value[0];
                CFG_DOUBLE_RESOLUTION: double_res = value[0];
                CFG_BOUNDS_ENABLE:     bounds_en = value[0];
                CFG_LOWER_LIMIT:       lower = longint'($signed(value));
                CFG_UPPER_LIMIT:       upper = longint'($signed(value));
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        // Advances the predicted state by one accepted input word.
        function void note_input(bit func, bit pin_a, bit pin_b);
            bit [1:0] phase;
            int       dq;
            int       thr;
            int       step;
            int       hit;
            longint   target;
            t_result  r;
            phase = {pin_a, pin_b};
            step = 0;
            hit = 0;
            if (func) begin
                net = '0;
                total = '0;
                accum = 0;
                last_sign = 0;
                synced = 1'b0;
                clears++;
            end else if (!synced) begin
                prev_phase = phase;
                synced = 1'b1;
            end else begin
                dq = QUARTER_STEP[{prev_phase, phase}];
                if (dq != 0) begin
                    if (invert)
                        dq = -dq;
                end else if ((prev_phase ^ phase) == 2'b11 && last_sign != 0) begin
                    // A skipped phase repeats the last counted direction, already inverted.
                    dq = 2 * last_sign;
                end
                prev_phase = phase;
                if (dq != 0) begin
                    thr = double_res ? 2 : 4;
                    last_sign = (dq > 0) ? 1 : -1;
                    accum += dq;
                    if (accum >= thr) begin
                        step = 1;
                        accum -= thr;
                    end else if (accum <= -thr) begin
                        step = -1;
                        accum += thr;
                    end
                end
                if (step != 0) begin
                    dir = (step > 0);
                    target = longint'($signed(net)) + step;
                    if (bounds_en && (target < lower || target > upper)) begin
                        hit = step;
                        step = 0;
                        accum = 0;
                        rejects++;
                    end else begin
                        net = net + step;
                        total = total + 1;
                        detents++;
                    end
                end
            end
            r.step_event     = step[1:0];
            r.boundary_hit   = hit[1:0];
            r.last_direction = dir;
            r.net_count      = net;
            r.total_count    = total;
            expected_words.push_back(r);
        endfunction

        // Counts every mismatch; the printout stops after a few dozen lines.
        task report(string msg);
            errors++;
            if (errors <= 40)
                $display("mismatch: %s", msg);
        endtask

        task check_result(logic [71:0] word);
            t_result want;
            string   bad;
            checked++;
            if (expected_words.size() == 0) begin
                report($sformatf("result word %0d arrived with nothing expected: %h",
                                 checked, word));
                return;
            end
            want = expected_words.pop_front();
            bad = "";
            if (word[1:0] !== want.step_event)
                bad = {bad, $sformatf(" step_event %0d want %0d",
                                      $signed(word[1:0]), want.step_event)};
            if (word[3:2] !== want.boundary_hit)
                bad = {bad, $sformatf(" boundary_hit %0d want %0d",
                                      $signed(word[3:2]), want.boundary_hit)};
            if (word[4] !== want.last_direction)
                bad = {bad, $sformatf(" last_direction %b want %b",
                                      word[4], want.last_direction)};
            if (word[36:5] !== want.net_count)
                bad = {bad, $sformatf(" net_count %0d want %0d",
                                      $signed(word[36:5]), want.net_count)};
            if (word[68:37] !== want.total_count)
                bad = {bad, $sformatf(" total_count %0d want %0d",
                                      word[68:37], want.total_count)};
            if (word[71:69] !== 3'b000)
                bad = {bad, $sformatf(" padding %b", word[71:69])};
            if (bad != "")
                report($sformatf("result word %0d:%s", checked, bad));
        endtask

    endclass

endpackage

/* tb/testbench.sv */
// Testbench for quadrature_step_counter: drives encoder samples and clears,
// checks every result word against qsc_scoreboard_pkg. Depends on qsc_pkg.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import qsc_pkg::*;
    import qsc_scoreboard_pkg::*;

    typedef enum int {RX_FREE, RX_RANDOM, RX_PERIODIC, RX_TRICKLE} t_rx_mode;

    // Raw phases in forward order.
    localparam bit [1:0] GRAY_CYCLE [4] = '{2'd0, 2'd2, 2'd3, 2'd1};

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [7:0]  i_s_tdata = '0;    // [0] pin_a, [1] pin_b, rest zero
    logic        i_s_tuser = 1'b0;  // [0] func
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [71:0] o_m_tdata;         // [1:0] step_event, [3:2] boundary_hit,
                                    // [4] last_direction, [36:5] net_count,
                                    // [68:37] total_count, rest zero
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_addr = '0;
    logic [31:0] i_cfg_data = '0;

    qsc_scoreboard sb = new();

    bit       sending = 1'b0;
    int       burst_left = 0;
    bit [1:0] pos = 2'd0;
    bit       walk_fwd = 1'b1;
    int       settings_used = 0;

    t_rx_mode rx_mode = RX_FREE;
    int       rx_left = 0;
    int       rx_tick = 0;

    quadrature_step_counter i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Result side: check accepted words, then pick the next ready level.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata);
        if (rx_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_left = $urandom_range(50, 250);
        end else begin
            rx_left--;
        end
        case (rx_mode)
            RX_FREE:     i_m_tready <= 1'b1;
            RX_RANDOM:   i_m_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: i_m_tready <= ((rx_tick % 5) < 3);
            default:     i_m_tready <= ($urandom_range(0, 15) == 0);
        endcase
        rx_tick++;
    end

    // Offers one word, waits for it to be taken and inserts a gap after a burst.
    task automatic push(bit func, bit pin_a, bit pin_b);
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= func;
        i_s_tdata  <= {6'b0, pin_b, pin_a};
        sending = 1'b1;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_input(func, pin_a, pin_b);
        if (burst_left == 0) begin
            i_s_tvalid <= 1'b0;
            sending = 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 200)
                                                     : $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
    endtask

    // Stops sending and waits until every expected word has come back.
    task automatic drain();
        if (sending) begin
            i_s_tvalid <= 1'b0;
            sending = 1'b0;
        end
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_settings(bit inv, bit dbl, bit bnd, int lower, int upper);
        logic [2:0]  addr [5];
        logic [31:0] val [5];
        addr = '{CFG_INVERT_DIRECTION, CFG_DOUBLE_RESOLUTION, CFG_BOUNDS_ENABLE,
                 CFG_LOWER_LIMIT, CFG_UPPER_LIMIT};
        // Upper bits of the flag registers are junk that the block must ignore.
        val[0] = $urandom;
        val[0][0] = inv;
        val[1] = $urandom;
        val[1][0] = dbl;
        val[2] = $urandom;
        val[2][0] = bnd;
        val[3] = lower;
        val[4] = upper;
        for (int k = 0; k < 5; k++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_addr <= addr[k];
            i_cfg_data <= val[k];
            sb.configure(addr[k], val[k]);
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Mostly clean quadrature walks, with skipped phases, holds, noise and clears.
    task automatic random_run(int count);
        int       roll;
        bit [1:0] ph;
        for (int k = 0; k < count; k++) begin
            if (k == count / 2)
                drain();
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                push(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end else begin
                if (roll < 6) begin
                    pos = 2'($urandom_range(0, 3));
                end else if (roll < 12) begin
                    pos = pos + 2'd2;
                end else if (roll >= 20) begin
                    if ($urandom_range(0, 9) == 0)
                        walk_fwd = !walk_fwd;
                    pos = walk_fwd ? pos + 2'd1 : pos - 2'd1;
                end
                ph = GRAY_CYCLE[pos];
                push(1'b0, ph[1], ph[0]);
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Plain counting: latch, skipped phase with no direction, one full detent,
        // rebuilt double quarters, then a clear and resync.
        write_settings(1'b0, 1'b0, 1'b0, 0, 0);
        push(1'b0, 1'b0, 1'b0);
        push(1'b0, 1'b1, 1'b1);
        push(1'b0, 1'b0, 1'b0);
        push(1'b0, 1'b1, 1'b0);
        push(1'b0, 1'b1, 1'b1);
        push(1'b0, 1'b0, 1'b1);
        push(1'b0, 1'b0, 1'b0);
        push(1'b0, 1'b1, 1'b1);
        push(1'b0, 1'b0, 1'b0);
        push(1'b0, 1'b0, 1'b1);
        push(1'b1, 1'b1, 1'b1);
        push(1'b0, 1'b1, 1'b1);
        push(1'b0, 1'b1, 1'b1);
        push(1'b0, 1'b0, 1'b0);

        // Inverted, double resolution, tight bounds: lower and upper rejects,
        // including rebuilt moves that must not be inverted twice.
        drain();
        write_settings(1'b1, 1'b1, 1'b1, 0, 1);
        push(1'b0, 1'b1, 1'b0);
        push(1'b0, 1'b1, 1'b1);
        push(1'b0, 1'b0, 1'b0);
        push(1'b0, 1'b0, 1'b1);
        push(1'b0, 1'b1, 1'b1);
        push(1'b0, 1'b1, 1'b0);
        push(1'b0, 1'b0, 1'b0);
        push(1'b0, 1'b1, 1'b1);
        pos = 2'd2;

        drain();
        write_settings(1'b0, 1'b0, 1'b1, 32'sh8000_0000, 32'sh7fff_ffff);
        random_run(105);
        drain();
        write_settings(1'b1, 1'b0, 1'b1, -3, 2);
        random_run(105);
        drain();
        write_settings(1'b0, 1'b1, 1'b1, 5, -5);
        random_run(105);
        drain();
        write_settings(1'b1, 1'b1, 1'b0, 32'sh7fff_ffff, 32'sh8000_0000);
        random_run(105);
        drain();
        write_settings(1'b0, 1'b1, 1'b1, 0, 0);
        random_run(105);
        drain();
        write_settings(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1,
                       int'($urandom_range(0, 8)) - 6, int'($urandom_range(0, 8)) - 2);
        random_run(105);
        drain();

        $display("%0d result words checked under %0d register settings:", sb.checked,
                 settings_used);
        $display("%0d detents counted, %0d rejected at a bound, %0d clears", sb.detents,
                 sb.rejects, sb.clears);
        if (sb.errors == 0) begin
            $display("[quadrature_step_counter] OK");
        end else begin
            $display("[quadrature_step_counter] ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d words still expected", sb.pending());
        $display("[quadrature_step_counter] ERROR");
        $finish;
    end

endmodule
